// ===== design/rsgd_pkg.sv =====
package rsgd_pkg;

  // vector geometry
  localparam int DIM    = 16;
  localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;

  // field widths
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int ITER_W    = 16;
  localparam int EIDX_W    = 6;
  localparam int ST_W      = 2;

  // arithmetic widths
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 34;
  localparam int QUO_W  = 32;
  localparam int RAD_W  = 68;
  localparam int ROOT_W = 34;
  localparam int DOT_W  = 69;

  // opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_GRAD  = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_STEP  = 2'd0;
  localparam logic [ST_W-1:0] ST_MAXIT = 2'd1;
  localparam logic [ST_W-1:0] ST_TOL   = 2'd2;
  localparam logic [ST_W-1:0] ST_SMALL = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXIMIZE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAX    = 3'd5;

  // multiplier operand selects
  localparam logic [1:0] MUL_SQ  = 2'd0;
  localparam logic [1:0] MUL_DOT = 2'd1;
  localparam logic [1:0] MUL_RLX = 2'd2;
  localparam logic [1:0] MUL_DLT = 2'd3;

  typedef struct packed {
    logic             start_opt;
    logic             take_in;
    logic             div_start;
    logic             div_dlt;
    logic             store_inc;
    logic             clear_inc;
    logic             rotate;
    logic [1:0]       mul_sel;
    logic             acc_sq;
    logic             acc_dot;
    logic             sqrt_start;
    logic             step_relax;
    logic             iter_inc;
    logic             out_load;
    logic [ST_W-1:0]  out_status;
    logic             out_last;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic             div_done;
    logic             sqrt_done;
    logic             last_elem;
    logic             iter_ge;
    logic             mag_lt_tol;
    logic             dot_neg;
    logic             step_lt_min;
    logic             out_free;
    logic [IDX_W-1:0] nlast;
  } sts_t;

endpackage

// ===== design/regular_step_gradient_descent.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------
// in       | in_valid/in_ready  | opcode, gradient_value, scale_value, last_element
// out      | out_valid/out_ready| step_delta, element_index, status, iteration,
//          |                    | last_result
// cfg      | cfg_we             | cfg_index, cfg_data
//
// A start request is handled as it is accepted; a gradient element is scaled in
// the shared radix-2 divider. Closing a vector accumulates squares and dot
// products on the shared multiplier, then runs the bit-serial square root and a
// multiply plus divide per delta, one request at a time.
// Synchronous active-low reset; no clearing pass. A stalled output holds its
// result and the block then waits before loading the next one.
module regular_step_gradient_descent (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [rsgd_pkg::DATA_W-1:0]     in_gradient_value,
  input  logic [rsgd_pkg::CFG_W-1:0]      in_scale_value,
  input  logic                            in_last_element,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rsgd_pkg::DATA_W-1:0]     out_step_delta,
  output logic [rsgd_pkg::EIDX_W-1:0]     out_element_index,
  output logic [rsgd_pkg::ST_W-1:0]       out_status,
  output logic [rsgd_pkg::ITER_W-1:0]     out_iteration,
  output logic                            out_last_result,
  input  logic                            cfg_we,
  input  logic [rsgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsgd_pkg::CFG_W-1:0]      cfg_data
);
  import rsgd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rsgd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsgd_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_gradient_value (in_gradient_value),
    .in_scale_value    (in_scale_value),
    .in_last_element   (in_last_element),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_step_delta    (out_step_delta),
    .out_element_index (out_element_index),
    .out_status        (out_status),
    .out_iteration     (out_iteration),
    .out_last_result   (out_last_result)
  );

  // a result is loaded only into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending one");

  // divider never finishes while new requests are taken
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> !in_ready)
    else $error("divider finished while idle");

  // iteration count moves only with a loaded final result
  a_iter_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.iter_inc |-> (cmd.out_load && cmd.out_last))
    else $error("iteration count moved without a final result");

endmodule

// ===== design/rsgd_div.sv =====
module rsgd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rsgd_pkg::NUM_W-1:0]  num,
  input  logic [rsgd_pkg::DEN_W-1:0]  den,
  output logic                        done,
  output logic                        ovf,
  output logic [rsgd_pkg::QUO_W-1:0]  quo
);
  import rsgd_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic               busy_r, done_r, ovf_r;
  logic [DEN_W-1:0]   den_r, rem_r;
  logic [QUO_W-1:0]   low_r, q_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DEN_W:0]     trial;
  logic               fits;
  logic               big;
  logic               den_zero;

  // quotient would not fit in QUO_W bits: saturate at once
  assign big   = ({{(DEN_W-(NUM_W-QUO_W)){1'b0}}, num[NUM_W-1:QUO_W]} >= den) && (num != '0);
  // zero divisor: saturate when the dividend is nonzero, else a zero quotient
  assign den_zero = (den == '0);
  assign trial = {rem_r, low_r[QUO_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        rem_r <= DEN_W'(num[NUM_W-1:QUO_W]);
        low_r <= num[QUO_W-1:0];
        q_r   <= '0;
        cnt_r <= '0;
        ovf_r <= big;
        if (big || den_zero) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        q_r   <= {q_r[QUO_W-2:0], fits};
        low_r <= {low_r[QUO_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign ovf  = ovf_r;
  assign quo  = q_r;

endmodule

// ===== design/rsgd_sqrt.sv =====
module rsgd_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rsgd_pkg::RAD_W-1:0]   rad,
  output logic                         done,
  output logic [rsgd_pkg::ROOT_W-1:0]  root
);
  import rsgd_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_r, done_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [REM_W-1:0]  r2, trial;
  logic              ge;

  assign r2    = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = r2 >= trial;

  // digit-by-digit root, one bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= ge ? r2 - trial : r2;
        root_r <= {root_r[ROOT_W-2:0], ge};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== design/rsgd_dpath.sv =====
module rsgd_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rsgd_pkg::cmd_t                  cmd,
  output rsgd_pkg::sts_t                  sts,
  input  logic                            cfg_we,
  input  logic [rsgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsgd_pkg::CFG_W-1:0]      cfg_data,
  input  logic [rsgd_pkg::DATA_W-1:0]     in_gradient_value,
  input  logic [rsgd_pkg::CFG_W-1:0]      in_scale_value,
  input  logic                            in_last_element,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [rsgd_pkg::DATA_W-1:0]     out_step_delta,
  output logic [rsgd_pkg::EIDX_W-1:0]     out_element_index,
  output logic [rsgd_pkg::ST_W-1:0]       out_status,
  output logic [rsgd_pkg::ITER_W-1:0]     out_iteration,
  output logic                            out_last_result
);
  import rsgd_pkg::*;

  // saturate a sign and magnitude into a signed word
  function automatic logic [DATA_W-1:0] sat_q(input logic neg, input logic ovf,
                                              input logic [QUO_W-1:0] q);
    logic [DATA_W-1:0] r;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) r = 32'h8000_0000;
      else r = ~q + 32'd1;
    end else begin
      if (ovf || q[QUO_W-1]) r = 32'h7FFF_FFFF;
      else r = q;
    end
    return r;
  endfunction

  // configuration
  logic [CFG_W-1:0]  max_step_r, min_step_r, tol_r;
  logic [ITER_W-1:0] limit_r;
  logic              maximize_r;
  logic [15:0]       relax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r <= CFG_W'(65536);
      min_step_r <= CFG_W'(66);
      tol_r      <= CFG_W'(7);
      limit_r    <= ITER_W'(100);
      maximize_r <= 1'b0;
      relax_r    <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_STEP: max_step_r <= cfg_data;
        CFG_MIN_STEP: min_step_r <= cfg_data;
        CFG_TOL:      tol_r      <= cfg_data;
        CFG_LIMIT:    limit_r    <= cfg_data[ITER_W-1:0];
        CFG_MAXIMIZE: maximize_r <= cfg_data[0];
        CFG_RELAX:    relax_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // request side latch
  logic gneg_r, last_r;
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      gneg_r <= in_gradient_value[DATA_W-1];
      last_r <= in_last_element;
    end
  end

  // shared divider
  logic [DATA_W-1:0] gmag;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done, div_ovf;
  logic [QUO_W-1:0]  div_quo;
  logic [NUM_W-1:0]  prod_r;
  logic              sqrt_done;
  logic [ROOT_W-1:0] mag;

  assign gmag    = in_gradient_value[DATA_W-1] ? ~in_gradient_value + 32'd1 : in_gradient_value;
  assign div_num = cmd.div_dlt ? prod_r : {16'd0, gmag, 16'd0};
  assign div_den = cmd.div_dlt ? mag : DEN_W'(in_scale_value);

  rsgd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .ovf   (div_ovf),
    .quo   (div_quo)
  );

  // gradient stores
  logic [DATA_W-1:0] inc_r  [DIM];
  logic [DATA_W-1:0] cur_r  [DIM];
  logic [DATA_W-1:0] prev_r [DIM];
  logic [IDX_W-1:0]  fill_r, nlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start_opt) begin
      for (int i = 0; i < DIM; i++) begin
        inc_r[i]  <= '0;
        cur_r[i]  <= '0;
        prev_r[i] <= '0;
      end
      fill_r <= '0;
    end else begin
      if (cmd.store_inc) begin
        inc_r[fill_r] <= sat_q(gneg_r, div_ovf, div_quo);
        if (last_r) begin
          nlast_r <= fill_r;
          fill_r  <= '0;
        end else if (fill_r != IDX_W'(DIM - 1)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.clear_inc) begin
        for (int i = 0; i < DIM; i++) inc_r[i] <= '0;
      end
      if (cmd.rotate) begin
        for (int i = 0; i < DIM; i++) begin
          prev_r[i] <= cur_r[i];
          cur_r[i]  <= inc_r[i];
          inc_r[i]  <= '0;
        end
      end
    end
  end

  // element operands
  logic [DATA_W-1:0] cur_e, prev_e, abs_c, abs_p;
  assign cur_e  = cur_r[cmd.idx];
  assign prev_e = prev_r[cmd.idx];
  assign abs_c  = cur_e[DATA_W-1] ? ~cur_e + 32'd1 : cur_e;
  assign abs_p  = prev_e[DATA_W-1] ? ~prev_e + 32'd1 : prev_e;

  // shared multiplier, registered product
  logic [CFG_W-1:0]  step_r;
  logic [DATA_W-1:0] ma, mb;
  always_comb begin
    case (cmd.mul_sel)
      MUL_SQ:  begin ma = abs_c;                mb = abs_c;            end
      MUL_DOT: begin ma = abs_c;                mb = abs_p;            end
      MUL_RLX: begin ma = DATA_W'(step_r);      mb = DATA_W'(relax_r); end
      default: begin ma = DATA_W'(step_r);      mb = abs_c;            end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  // sum of squares and dot product
  logic [RAD_W-1:0] sumsq_r;
  logic [DOT_W-1:0] dot_r;
  always_ff @(posedge clk) begin
    if (cmd.rotate) begin
      sumsq_r <= '0;
      dot_r   <= '0;
    end else begin
      if (cmd.acc_sq) sumsq_r <= sumsq_r + RAD_W'(prod_r);
      if (cmd.acc_dot) begin
        if (cur_e[DATA_W-1] != prev_e[DATA_W-1]) dot_r <= dot_r - DOT_W'(prod_r);
        else dot_r <= dot_r + DOT_W'(prod_r);
      end
    end
  end

  rsgd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .rad   (sumsq_r),
    .done  (sqrt_done),
    .root  (mag)
  );

  // step length and iteration count
  logic [ITER_W-1:0] iter_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= CFG_W'(65536);
      iter_r <= '0;
    end else if (cmd.start_opt) begin
      step_r <= max_step_r;
      iter_r <= '0;
    end else begin
      if (cmd.step_relax) step_r <= prod_r[CFG_W+15:16];
      if (cmd.iter_inc) iter_r <= iter_r + 1'b1;
    end
  end

  // result register
  logic              out_valid_r;
  logic              is_step;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign is_step = (cmd.out_status == ST_STEP);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_step_delta    <= (is_step && mag != '0) ?
                           sat_q(cur_e[DATA_W-1] != maximize_r, div_ovf, div_quo) : '0;
      out_element_index <= is_step ? EIDX_W'(cmd.idx) : '0;
      out_status        <= cmd.out_status;
      out_iteration     <= iter_r;
      out_last_result   <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;

  // status to the controller
  assign sts.div_done    = div_done;
  assign sts.sqrt_done   = sqrt_done;
  assign sts.last_elem   = last_r;
  assign sts.iter_ge     = iter_r >= limit_r;
  assign sts.mag_lt_tol  = mag < DEN_W'(tol_r);
  assign sts.dot_neg     = dot_r[DOT_W-1];
  assign sts.step_lt_min = step_r < min_step_r;
  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.nlast       = nlast_r;

endmodule

// ===== design/rsgd_ctrl.sv =====
module rsgd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_opcode,
  output logic            in_ready,
  input  rsgd_pkg::sts_t  sts,
  output rsgd_pkg::cmd_t  cmd
);
  import rsgd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_MSQ   = 4'd3;
  localparam logic [3:0] S_MDOT  = 4'd4;
  localparam logic [3:0] S_MACC  = 4'd5;
  localparam logic [3:0] S_SQW   = 4'd6;
  localparam logic [3:0] S_TOL   = 4'd7;
  localparam logic [3:0] S_RLX   = 4'd8;
  localparam logic [3:0] S_MINC  = 4'd9;
  localparam logic [3:0] S_DMUL  = 4'd10;
  localparam logic [3:0] S_DDIV  = 4'd11;
  localparam logic [3:0] S_DWAIT = 4'd12;
  localparam logic [3:0] S_DOUT  = 4'd13;
  localparam logic [3:0] S_ESTAT = 4'd14;

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;
  logic             at_last;

  assign at_last = (idx_r == sts.nlast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      st_r    <= ST_STEP;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      st_r    <= st_nxt;
    end
  end

  // sequencing
  always_comb begin
    cmd       = '0;
    cmd.idx   = idx_r;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    st_nxt    = st_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          if (in_opcode == OP_START) begin
            cmd.start_opt = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIVE;
          end
        end
      end
      S_DIVE: begin
        if (sts.div_done) begin
          cmd.store_inc = 1'b1;
          state_nxt     = sts.last_elem ? S_CHK : S_IDLE;
        end
      end
      S_CHK: begin
        if (sts.iter_ge) begin
          cmd.clear_inc = 1'b1;
          st_nxt        = ST_MAXIT;
          state_nxt     = S_ESTAT;
        end else begin
          cmd.rotate = 1'b1;
          idx_nxt    = '0;
          state_nxt  = S_MSQ;
        end
      end
      S_MSQ: begin
        cmd.mul_sel = MUL_SQ;
        state_nxt   = S_MDOT;
      end
      S_MDOT: begin
        cmd.acc_sq  = 1'b1;
        cmd.mul_sel = MUL_DOT;
        state_nxt   = S_MACC;
      end
      S_MACC: begin
        cmd.acc_dot = 1'b1;
        if (at_last) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQW;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_MSQ;
        end
      end
      S_SQW: begin
        if (sts.sqrt_done) state_nxt = S_TOL;
      end
      S_TOL: begin
        if (sts.mag_lt_tol) begin
          st_nxt    = ST_TOL;
          state_nxt = S_ESTAT;
        end else if (sts.dot_neg) begin
          cmd.mul_sel = MUL_RLX;
          state_nxt   = S_RLX;
        end else begin
          state_nxt = S_MINC;
        end
      end
      S_RLX: begin
        cmd.step_relax = 1'b1;
        state_nxt      = S_MINC;
      end
      S_MINC: begin
        if (sts.step_lt_min) begin
          st_nxt    = ST_SMALL;
          state_nxt = S_ESTAT;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_DMUL;
        end
      end
      S_DMUL: begin
        cmd.mul_sel = MUL_DLT;
        state_nxt   = S_DDIV;
      end
      S_DDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_dlt   = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        cmd.div_dlt = 1'b1;
        if (sts.div_done) state_nxt = S_DOUT;
      end
      S_DOUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_STEP;
          cmd.out_last   = at_last;
          if (at_last) begin
            cmd.iter_inc = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_DMUL;
          end
        end
      end
      S_ESTAT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = st_r;
          cmd.out_last   = 1'b1;
          cmd.iter_inc   = (st_r != ST_MAXIT);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== tb/regular_step_gradient_descent_tb.sv =====
module regular_step_gradient_descent_tb;
  import rsgd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = DIM;

  // one expected result
  typedef struct {
    logic [DATA_W-1:0] delta;
    logic [EIDX_W-1:0] eidx;
    logic [ST_W-1:0]   st;
    logic [ITER_W-1:0] iter;
    logic              last;
  } delta_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_opcode = OP_START;
  logic [DATA_W-1:0]    in_gradient_value = '0;
  logic [CFG_W-1:0]     in_scale_value = '0;
  logic                 in_last_element = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DATA_W-1:0]    out_step_delta;
  logic [EIDX_W-1:0]    out_element_index;
  logic [ST_W-1:0]      out_status;
  logic [ITER_W-1:0]    out_iteration;
  logic                 out_last_result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_STEP;
  logic [CFG_W-1:0]     cfg_data = '0;

  regular_step_gradient_descent i_dut (.*);

  // clock, 12 ns
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the optimiser state
  logic [30:0]        sh_max_step, sh_min_step, sh_tol;
  logic [15:0]        sh_limit, sh_relax;
  logic               sh_maximize;
  logic signed [31:0] cur_grad[NSLOT], prev_grad[NSLOT], inc_grad[NSLOT];
  logic [63:0]        step_len;
  logic [15:0]        iter_cnt;
  int                 fill_pos;

  delta_res_t expected_deltas[$];
  int  errors = 0;
  int  n_req = 0, n_res = 0, n_stop = 0;
  bit  calm = 1'b0;
  int  stall_left = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] mag_of(logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  function automatic logic [31:0] clamp_signed(bit neg, logic [63:0] q);
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -q[31:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic clear_grads();
    for (int i = 0; i < NSLOT; i++) begin
      cur_grad[i] = 0;
      prev_grad[i] = 0;
      inc_grad[i] = 0;
    end
    fill_pos = 0;
  endtask

  task automatic push_res(logic [31:0] d, int idx, logic [ST_W-1:0] st, bit last);
    delta_res_t r;
    r.delta = d;
    r.eidx = idx[EIDX_W-1:0];
    r.st = st;
    r.iter = iter_cnt;
    r.last = last;
    expected_deltas.push_back(r);
    if (st != ST_STEP) n_stop++;
  endtask

  // works out what one accepted request produces
  task automatic predict_descent(logic op, logic [31:0] g, logic [30:0] s, logic last);
    bit                 gneg, neg;
    logic [63:0]        gmag, q, ca, mag, num;
    logic [71:0]        sumsq, t;
    logic [127:0]       dpos, dneg;
    logic signed [31:0] e;
    int                 n;
    if (op == OP_START) begin
      clear_grads();
      step_len = sh_max_step;
      iter_cnt = '0;
      return;
    end
    gneg = g[31];
    gmag = gneg ? (64'h1_0000_0000 - g) : {32'd0, g};
    if (s == 0) q = (gmag != 0) ? 64'h8000_0000 : 64'd0;
    else q = (gmag << 16) / s;
    if (fill_pos >= NSLOT) fill_pos = NSLOT - 1;
    inc_grad[fill_pos] = clamp_signed(gneg, q);
    if (!last) begin
      if (fill_pos < NSLOT - 1) fill_pos++;
      return;
    end
    n = fill_pos + 1;
    fill_pos = 0;
    if (iter_cnt >= sh_limit) begin
      for (int i = 0; i < NSLOT; i++) inc_grad[i] = 0;
      push_res('0, 0, ST_MAXIT, 1'b1);
      return;
    end
    // rotate the vectors
    for (int i = 0; i < NSLOT; i++) begin
      prev_grad[i] = cur_grad[i];
      cur_grad[i] = (i < n) ? inc_grad[i] : 0;
      inc_grad[i] = 0;
    end
    sumsq = '0; dpos = '0; dneg = '0;
    for (int i = 0; i < n; i++) begin
      ca = mag_of(cur_grad[i]);
      sumsq = sumsq + ca * ca;
      if ((cur_grad[i] < 0) != (prev_grad[i] < 0))
        dneg = dneg + 128'(ca) * 128'(mag_of(prev_grad[i]));
      else
        dpos = dpos + 128'(ca) * 128'(mag_of(prev_grad[i]));
    end
    // bit-serial square root
    mag = '0;
    for (int sh = 35; sh >= 0; sh--) begin
      t = 72'(mag) | (72'd1 << sh);
      if (t * t <= sumsq) mag = t[63:0];
    end
    if (mag < sh_tol) begin
      push_res('0, 0, ST_TOL, 1'b1);
      iter_cnt++;
      return;
    end
    if (dneg > dpos) step_len = (step_len * sh_relax) >> 16;
    if (step_len < sh_min_step) begin
      push_res('0, 0, ST_SMALL, 1'b1);
      iter_cnt++;
      return;
    end
    for (int i = 0; i < n; i++) begin
      e = cur_grad[i];
      if (mag == 0) push_res('0, i, ST_STEP, i + 1 == n);
      else begin
        num = step_len * mag_of(e);
        neg = (e < 0) != (sh_maximize == 1'b1);
        push_res(clamp_signed(neg, num / mag), i, ST_STEP, i + 1 == n);
      end
    end
    iter_cnt++;
  endtask

  // sends one request; valid stays high into the next one when there is no gap
  task automatic send_req(logic op, logic [31:0] g, logic [30:0] s, logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_gradient_value <= g;
    in_scale_value <= s;
    in_last_element <= last;
    do @(posedge clk); while (!in_ready);
    predict_descent(op, g, s, last);
    n_req++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_STEP: sh_max_step = d;
      CFG_MIN_STEP: sh_min_step = d;
      CFG_TOL:      sh_tol = d;
      CFG_LIMIT:    sh_limit = d[15:0];
      CFG_MAXIMIZE: sh_maximize = d[0];
      CFG_RELAX:    sh_relax = d[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [30:0] mx, logic [30:0] mn, logic [30:0] tol,
                          logic [15:0] lim, logic maxim, logic [15:0] rlx);
    write_reg(CFG_MAX_STEP, mx);
    write_reg(CFG_MIN_STEP, mn);
    write_reg(CFG_TOL, tol);
    write_reg(CFG_LIMIT, {15'd0, lim});
    write_reg(CFG_MAXIMIZE, {30'd0, maxim});
    write_reg(CFG_RELAX, {15'd0, rlx});
  endtask

  // drain: all results in, then a margin for a divide still running
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_deltas.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_grad();
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    v = $urandom;
    if (r < 5) v = {{12{v[31]}}, v[19:0]};
    else if (r == 9) v = {v[31], 31'd0};
    return v;
  endfunction

  function automatic logic [30:0] rand_scale();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 4) return 31'($urandom);
    return 31'($urandom_range(1 << 12, 1 << 20));
  endfunction

  task automatic send_vector(int n);
    for (int i = 0; i < n; i++)
      send_req(OP_GRAD, rand_grad(), rand_scale(), i == n - 1);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_res);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    delta_res_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_deltas.size() == 0) begin
        report_mismatch("unexpected result", out_step_delta, '0);
      end else begin
        w = expected_deltas.pop_front();
        if (out_step_delta !== w.delta) report_mismatch("step_delta", out_step_delta, w.delta);
        if (out_element_index !== w.eidx)
          report_mismatch("element_index", out_element_index, w.eidx);
        if (out_status !== w.st) report_mismatch("status", out_status, w.st);
        if (out_iteration !== w.iter) report_mismatch("iteration", out_iteration, w.iter);
        if (out_last_result !== w.last)
          report_mismatch("last_result", out_last_result, w.last);
      end
      n_res++;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // default registers: extremes of the fields, zero scale, sign flip, zero vector
  task automatic test_defaults();
    send_req(OP_START, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    send_req(OP_GRAD, 32'h8000_0000, 31'd1, 1'b0);
    send_req(OP_GRAD, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_req(OP_GRAD, 32'h0001_0000, 31'd0, 1'b0);
    send_req(OP_GRAD, 32'd0, 31'd0, 1'b1);
    send_req(OP_GRAD, 32'hFFFF_0000, 31'h0001_0000, 1'b1);
    send_req(OP_GRAD, 32'h0000_0000, 31'h0001_0000, 1'b1);
    wait_idle();
  endtask

  // largest step, no thresholds, maximise, relaxation just under one
  task automatic test_wide_open();
    set_regs(31'h7FFF_FFFF, '0, '0, 16'hFFFF, 1'b1, 16'hFFFF);
    send_req(OP_START, '0, '0, 1'b0);
    send_req(OP_GRAD, '0, 31'd5, 1'b1);
    send_req(OP_GRAD, 32'h7FFF_FFFF, 31'd1, 1'b0);
    send_req(OP_GRAD, 32'h0000_0001, 31'h7FFF_FFFF, 1'b1);
    send_req(OP_GRAD, 32'h8000_0001, 31'd3, 1'b1);
    wait_idle();
  endtask

  // step-too-small, max iterations and an overlong vector
  task automatic test_stops();
    set_regs(31'd1, 31'h7FFF_FFFF, '0, 16'd2, 1'b0, '0);
    send_req(OP_START, '0, '0, 1'b0);
    send_req(OP_GRAD, 32'h0002_0000, 31'h0001_0000, 1'b1);
    wait_idle();
    set_regs(31'd65536, '0, 31'h7FFF_FFFF, 16'd0, 1'b0, 16'd32768);
    send_req(OP_GRAD, 32'h0002_0000, 31'h0001_0000, 1'b1);
    wait_idle();
    set_regs(31'd65536, 31'd66, 31'd7, 16'd100, 1'b0, 16'd32768);
    send_req(OP_START, '0, '0, 1'b0);
    send_vector(19);
    wait_idle();
  endtask

  // random register settings, mostly well-formed runs with some noise
  task automatic test_random(int phases, int per_phase);
    int cnt, r;
    for (int p = 0; p < phases; p++) begin
      calm = (p == 1);
      set_regs(($urandom_range(0, 1) ? 31'($urandom) | 31'd1 : 31'd65536),
               ($urandom_range(0, 2) == 0 ? 31'($urandom) : 31'($urandom_range(0, 200))),
               ($urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 50))),
               ($urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 30))),
               1'($urandom), 16'($urandom));
      cnt = 0;
      send_req(OP_START, $urandom, 31'($urandom), 1'($urandom));
      while (cnt < per_phase) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_req(OP_START, $urandom, 31'($urandom), 1'($urandom));
          cnt++;
        end else if (r == 1) begin
          send_vector(NSLOT + $urandom_range(1, 4));
          cnt += NSLOT + 2;
        end else if (r < 4) begin
          r = $urandom_range(5, NSLOT);
          send_vector(r);
          cnt += r;
        end else begin
          r = $urandom_range(1, 4);
          send_vector(r);
          cnt += r;
        end
      end
      wait_idle();
    end
    calm = 1'b0;
  endtask

  initial begin
    sh_max_step = 31'd65536;
    sh_min_step = 31'd66;
    sh_tol = 31'd7;
    sh_limit = 16'd100;
    sh_maximize = 1'b0;
    sh_relax = 16'd32768;
    clear_grads();
    step_len = 64'd65536;
    iter_cnt = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_wide_open();
    test_stops();
    test_random(5, 80);
    $display("covered %0d requests and %0d results, %0d of them stop reports",
             n_req, n_res, n_stop);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
